// ===== design/rgb565_convert_overlay_blend_core_macros.svh =====
// Assertion macros shared by the RGB565 convert and overlay blend design
`ifndef RGB565_CONVERT_OVERLAY_BLEND_CORE_MACROS_SVH
`define RGB565_CONVERT_OVERLAY_BLEND_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RGBCOB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb565cob assertion failed");

// next-cycle implication, disabled during reset
`define RGBCOB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb565cob assertion failed");

`endif

// ===== design/rgb565cob_pkg.sv =====
// Shared types and constants for the RGB565 convert and overlay blend core
package rgb565cob_pkg;

  localparam int CFG_DIM_W       = 11;
  localparam int CFG_DATA_W      = 11;
  localparam int CFG_INDEX_W     = 3;
  localparam int DEFAULT_MAX_DIM = 1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_FORMAT  = 3'd0,
    REG_SWAP_BYTES    = 3'd1,
    REG_DISP_WIDTH    = 3'd2,
    REG_DISP_HEIGHT   = 3'd3,
    REG_SOURCE_WIDTH  = 3'd4,
    REG_SOURCE_HEIGHT = 3'd5,
    REG_OVL_WIDTH     = 3'd6,
    REG_OVL_HEIGHT    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_ARGB8888 = 2'd2,
    FMT_BLACK    = 2'd3
  } pixel_format_t;

  localparam logic [CFG_DIM_W-1:0] RST_DISP_WIDTH    = 11'd320;
  localparam logic [CFG_DIM_W-1:0] RST_DISP_HEIGHT   = 11'd240;
  localparam logic [CFG_DIM_W-1:0] RST_SOURCE_WIDTH  = 11'd320;
  localparam logic [CFG_DIM_W-1:0] RST_SOURCE_HEIGHT = 11'd240;
  localparam logic [CFG_DIM_W-1:0] RST_OVL_WIDTH     = 11'd0;
  localparam logic [CFG_DIM_W-1:0] RST_OVL_HEIGHT    = 11'd0;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] disp_width;
    logic [CFG_DIM_W-1:0] disp_height;
    logic [CFG_DIM_W-1:0] source_width;
    logic [CFG_DIM_W-1:0] source_height;
    logic [CFG_DIM_W-1:0] ovl_width;
    logic [CFG_DIM_W-1:0] ovl_height;
  } dims_t;

  typedef struct packed {
    logic in_source;
    logic in_overlay;
    logic last;
  } pos_flags_t;

endpackage

// ===== design/rgb565cob_if.sv =====
// Valid/ready channel interfaces for pixel items in and results out
interface rgb565cob_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;
  logic [15:0] old_pixel;
  logic [31:0] overlay_pixel;

  modport source (output valid, output source_pixel, output old_pixel,
                  output overlay_pixel, input ready);
  modport sink   (input valid, input source_pixel, input old_pixel,
                  input overlay_pixel, output ready);
endinterface

interface rgb565cob_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pixel;
  logic        frame_last;

  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

// ===== design/rgb565_convert_overlay_blend_core.sv =====
// Top level: RGB565 conversion with ARGB8888 overlay blend, one pixel per item
// Path: an item taken goes into the input register, its result through the blend logic into the
// output register, from which it is offered; a stalled output can hold it in either register.
// Throughput: one item per clock while the output is not stalled; input register, blend logic, output register.
// A stalled output holds one result while an empty input register still takes an item.
// Reset clears both valid stages, the raster counters and the registers to defaults.
`include "rgb565_convert_overlay_blend_core_macros.svh"
module rgb565_convert_overlay_blend_core
  import rgb565cob_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                   clk,
  input  logic                   rst,
  rgb565cob_in_if.sink           pix_in,
  rgb565cob_out_if.source        pix_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pixel_format_t pixel_format;
  logic          swap_bytes;
  dims_t         dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format       <= FMT_ARGB8888;
      swap_bytes         <= 1'b0;
      dims.disp_width    <= RST_DISP_WIDTH;
      dims.disp_height   <= RST_DISP_HEIGHT;
      dims.source_width  <= RST_SOURCE_WIDTH;
      dims.source_height <= RST_SOURCE_HEIGHT;
      dims.ovl_width     <= RST_OVL_WIDTH;
      dims.ovl_height    <= RST_OVL_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PIXEL_FORMAT:  pixel_format       <= pixel_format_t'(cfg_data[1:0]);
        REG_SWAP_BYTES:    swap_bytes         <= cfg_data[0];
        REG_DISP_WIDTH:    dims.disp_width    <= cfg_data[CFG_DIM_W-1:0];
        REG_DISP_HEIGHT:   dims.disp_height   <= cfg_data[CFG_DIM_W-1:0];
        REG_SOURCE_WIDTH:  dims.source_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_SOURCE_HEIGHT: dims.source_height <= cfg_data[CFG_DIM_W-1:0];
        REG_OVL_WIDTH:     dims.ovl_width     <= cfg_data[CFG_DIM_W-1:0];
        REG_OVL_HEIGHT:    dims.ovl_height    <= cfg_data[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic        in_fire, s2_load;
  logic        s1_valid, s2_valid;
  logic [31:0] s1_src, s1_ovl;
  logic [15:0] s1_old, s2_pixel, pixel_next;
  logic        s2_last;
  pos_flags_t  pos_flags, s1_flags;

  assign s2_load      = s1_valid && (!s2_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || s2_load;
  assign in_fire      = pix_in.valid && pix_in.ready;

  rgb565cob_position #(
    .MAX_DIM (MAX_DIM)
  ) u_position (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .dims    (dims),
    .flags   (pos_flags)
  );

  // input register: item plus the area decode of its position
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_src   <= pix_in.source_pixel;
      s1_old   <= pix_in.old_pixel;
      s1_ovl   <= pix_in.overlay_pixel;
      s1_flags <= pos_flags;
    end
  end

  rgb565cob_blend u_blend (
    .pixel_format  (pixel_format),
    .swap_bytes    (swap_bytes),
    .flags         (s1_flags),
    .source_pixel  (s1_src),
    .old_pixel     (s1_old),
    .overlay_pixel (s1_ovl),
    .out_pixel     (pixel_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (pix_out.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_pixel <= pixel_next;
      s2_last  <= s1_flags.last;
    end
  end

  assign pix_out.valid      = s2_valid;
  assign pix_out.out_pixel  = s2_pixel;
  assign pix_out.frame_last = s2_last;

  `RGBCOB_ASSERT_NOW(a_ready_when_out_free, clk, rst, !s2_valid, pix_in.ready)
  `RGBCOB_ASSERT_NEXT(a_s1_kept_on_stall, clk, rst, s1_valid && !s2_load, s1_valid)
  `RGBCOB_ASSERT_NEXT(a_s2_filled_on_load, clk, rst, s2_load, s2_valid)

endmodule

// ===== design/rgb565cob_position.sv =====
// Raster position counters and source/overlay area decode
`include "rgb565_convert_overlay_blend_core_macros.svh"
module rgb565cob_position
  import rgb565cob_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  dims_t      dims,
  output pos_flags_t flags
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int LIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (CFG_DIM_W > LIM_W) ? CFG_DIM_W : LIM_W;
  localparam logic [CMP_W-1:0] MAX_V = CMP_W'(MAX_DIM);

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [CMP_W-1:0] dw, dh, dw_raw, dh_raw, x, y;
  logic             line_end, row_end;

  assign dw_raw = CMP_W'(dims.disp_width);
  assign dh_raw = CMP_W'(dims.disp_height);

  // zero is taken as one, anything above the maximum as the maximum
  always_comb begin
    if (dw_raw == '0) begin
      dw = CMP_W'(1);
    end else if (dw_raw > MAX_V) begin
      dw = MAX_V;
    end else begin
      dw = dw_raw;
    end
    if (dh_raw == '0) begin
      dh = CMP_W'(1);
    end else if (dh_raw > MAX_V) begin
      dh = MAX_V;
    end else begin
      dh = dh_raw;
    end
  end

  assign x = CMP_W'(column_count);
  assign y = CMP_W'(row_count);

  // at or past the last column/row counts as the end (display may shrink)
  assign line_end = x >= dw - CMP_W'(1);
  assign row_end  = y >= dh - CMP_W'(1);

  assign flags.in_source  = (x < CMP_W'(dims.source_width)) && (x < dw) &&
                            (y < CMP_W'(dims.source_height)) && (y < dh);
  assign flags.in_overlay = (x < CMP_W'(dims.ovl_width)) && (x < dw) &&
                            (y < CMP_W'(dims.ovl_height)) && (y < dh);
  assign flags.last       = line_end && row_end;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (advance) begin
      if (line_end) begin
        column_count_next = '0;
        row_count_next    = row_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count_next = column_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  `RGBCOB_ASSERT_NEXT(a_frame_wrap, clk, rst, advance && flags.last,
                      column_count == '0 && row_count == '0)
  `RGBCOB_ASSERT_NEXT(a_column_step, clk, rst, advance && !line_end,
                      column_count == $past(column_count) + CNT_W'(1) &&
                      row_count == $past(row_count))
  `RGBCOB_ASSERT_NEXT(a_hold_when_idle, clk, rst, !advance,
                      $stable(column_count) && $stable(row_count))

endmodule

// ===== design/rgb565cob_blend.sv =====
// Source conversion, overlay alpha blend and byte swap for one pixel
module rgb565cob_blend
  import rgb565cob_pkg::*;
(
  input  pixel_format_t pixel_format,
  input  logic          swap_bytes,
  input  pos_flags_t    flags,
  input  logic [31:0]   source_pixel,
  input  logic [15:0]   old_pixel,
  input  logic [31:0]   overlay_pixel,
  output logic [15:0]   out_pixel
);

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

  logic [15:0] conv, base, mixed, blended;
  logic [7:0]  a, inv, ovl_r, ovl_g, ovl_b, bg_r, bg_g, bg_b;
  logic [15:0] sum_r, sum_g, sum_b;

  always_comb begin
    unique case (pixel_format)
      FMT_RGB565:   conv = source_pixel[15:0];
      FMT_RGB888,
      FMT_ARGB8888: conv = pack565(source_pixel[23:16], source_pixel[15:8],
                                   source_pixel[7:0]);
      FMT_BLACK:    conv = '0;
      default:      conv = '0;
    endcase
  end

  assign base = flags.in_source ? conv : old_pixel;

  assign a     = overlay_pixel[31:24];
  assign ovl_r = overlay_pixel[23:16];
  assign ovl_g = overlay_pixel[15:8];
  assign ovl_b = overlay_pixel[7:0];
  assign inv   = 8'd255 - a;

  // background expanded with zero low bits
  assign bg_r = {base[15:11], 3'b000};
  assign bg_g = {base[10:5], 2'b00};
  assign bg_b = {base[4:0], 3'b000};

  // cannot exceed 255*255 + 128, so 16 bits hold it
  assign sum_r = 16'(ovl_r) * 16'(a) + 16'(bg_r) * 16'(inv) + 16'd128;
  assign sum_g = 16'(ovl_g) * 16'(a) + 16'(bg_g) * 16'(inv) + 16'd128;
  assign sum_b = 16'(ovl_b) * 16'(a) + 16'(bg_b) * 16'(inv) + 16'd128;

  assign mixed = pack565(sum_r[15:8], sum_g[15:8], sum_b[15:8]);

  always_comb begin
    priority if (!flags.in_overlay || a == 8'd0) begin
      blended = base;
    end else if (a == 8'd255) begin
      blended = pack565(ovl_r, ovl_g, ovl_b);
    end else begin
      blended = mixed;
    end
  end

  assign out_pixel = swap_bytes ? {blended[7:0], blended[15:8]} : blended;

endmodule

// ===== verif/rgb565cob_pixel_checker.sv =====
// Checker for the RGB565 convert and overlay blend core: predicts each pixel and compares results
module rgb565cob_pixel_checker
  import rgb565cob_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  rgb565cob_in_if                pix_in,
  rgb565cob_out_if               pix_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [15:0] out_pixel;
    logic        frame_last;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  // shadow copy of the registers and the raster position
  pixel_format_t fmt;
  logic          swap;
  dims_t         dims;
  logic [9:0]    col;
  logic [9:0]    row;

  function automatic int eff_dim(logic [CFG_DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [15:0] pack_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] blend_overlay(logic [15:0] bg, logic [31:0] argb);
    int a;
    int inv;
    int r;
    int g;
    int b;
    a = argb[31:24];
    if (a == 0) return bg;
    if (a == 255) return pack_rgb(argb[23:16], argb[15:8], argb[7:0]);
    inv = 255 - a;
    // background channels widened with zero low bits
    r = (int'(argb[23:16]) * a + int'({bg[15:11], 3'b000}) * inv + 128) >> 8;
    g = (int'(argb[15:8]) * a + int'({bg[10:5], 2'b00}) * inv + 128) >> 8;
    b = (int'(argb[7:0]) * a + int'({bg[4:0], 3'b000}) * inv + 128) >> 8;
    return pack_rgb(8'(r), 8'(g), 8'(b));
  endfunction

  // works out one result and moves the raster position on
  function automatic pixel_result_t predict_pixel(logic [31:0] src, logic [15:0] old,
                                                  logic [31:0] ovl);
    int            dw;
    int            dh;
    int            x;
    int            y;
    logic [15:0]   pix;
    pixel_result_t res;
    dw = eff_dim(dims.disp_width);
    dh = eff_dim(dims.disp_height);
    x  = col;
    y  = row;
    if (x < int'(dims.source_width) && x < dw && y < int'(dims.source_height) && y < dh) begin
      case (fmt)
        FMT_RGB565:   pix = src[15:0];
        FMT_RGB888,
        FMT_ARGB8888: pix = pack_rgb(src[23:16], src[15:8], src[7:0]);
        default:      pix = '0;
      endcase
    end else begin
      pix = old;
    end
    if (x < int'(dims.ovl_width) && x < dw && y < int'(dims.ovl_height) && y < dh) begin
      pix = blend_overlay(pix, ovl);
    end
    if (swap) pix = {pix[7:0], pix[15:8]};
    res.out_pixel  = pix;
    res.frame_last = 1'b0;
    // a counter past a shrunk edge counts as the last column or row
    if (x >= dw - 1) begin
      col = '0;
      if (y >= dh - 1) begin
        row = '0;
        res.frame_last = 1'b1;
      end else begin
        row = 10'(y + 1);
      end
    end else begin
      col = 10'(x + 1);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_result_t got;
    pixel_result_t want;
    if (rst) begin
      fmt  = FMT_ARGB8888;
      swap = 1'b0;
      dims = {RST_DISP_WIDTH, RST_DISP_HEIGHT, RST_SOURCE_WIDTH, RST_SOURCE_HEIGHT,
              RST_OVL_WIDTH, RST_OVL_HEIGHT};
      col  = '0;
      row  = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PIXEL_FORMAT:  fmt  = pixel_format_t'(cfg_data[1:0]);
          REG_SWAP_BYTES:    swap = cfg_data[0];
          REG_DISP_WIDTH:    dims.disp_width    = cfg_data;
          REG_DISP_HEIGHT:   dims.disp_height   = cfg_data;
          REG_SOURCE_WIDTH:  dims.source_width  = cfg_data;
          REG_SOURCE_HEIGHT: dims.source_height = cfg_data;
          REG_OVL_WIDTH:     dims.ovl_width     = cfg_data;
          REG_OVL_HEIGHT:    dims.ovl_height    = cfg_data;
          default: ;
        endcase
      end
      if (pix_out.valid && pix_out.ready) begin
        got.out_pixel  = pix_out.out_pixel;
        got.frame_last = pix_out.frame_last;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no item pending", got.out_pixel, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.out_pixel !== want.out_pixel) begin
            report_mismatch("out_pixel", got.out_pixel, want.out_pixel);
          end
          if (got.frame_last !== want.frame_last) begin
            report_mismatch("frame_last", 16'(got.frame_last), 16'(want.frame_last));
          end
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        expected_pixels.push_back(predict_pixel(pix_in.source_pixel, pix_in.old_pixel,
                                                pix_in.overlay_pixel));
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ===== verif/tb_rgb565_convert_overlay_blend_core.sv =====
// Testbench top for the RGB565 convert and overlay blend core: stimulus, flow control, verdict
module tb_rgb565_convert_overlay_blend_core
  import rgb565cob_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS  = 1750;
  localparam int LONG_LINE    = 1030;
  localparam int LONG_HOLD    = 120;
  localparam int CYCLE_LIMIT  = 300000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     outstanding;

  int items_sent  = 0;
  int burst_left  = 0;
  int hold_reqs   = 0;
  int hold_served = 0;

  rgb565cob_in_if  pix_in ();
  rgb565cob_out_if pix_out ();

  rgb565_convert_overlay_blend_core DUT (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgb565cob_pixel_checker pixel_checker (
    .clk         (clk),
    .rst         (rst),
    .pix_in      (pix_in),
    .pix_out     (pix_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: runs of differing stall patterns, plus a long hold-off on request
  initial begin
    int mode;
    int run_len;
    logic toggle;
    toggle = 1'b0;
    pix_out.ready <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(5, 60);
      repeat (run_len) begin
        @(posedge clk);
        if (hold_served != hold_reqs) begin
          hold_served = hold_reqs;
          pix_out.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        toggle = ~toggle;
        case (mode)
          0:       pix_out.ready <= 1'b1;
          1:       pix_out.ready <= 1'($urandom_range(0, 1));
          2:       pix_out.ready <= ($urandom_range(0, 3) == 0);
          default: pix_out.ready <= toggle;
        endcase
      end
    end
  end

  // called at a clock edge; returns at the edge where the item was taken
  task automatic send_pixel(logic [31:0] src, logic [15:0] old, logic [31:0] ovl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_in.valid         <= 1'b1;
    pix_in.source_pixel  <= src;
    pix_in.old_pixel     <= old;
    pix_in.overlay_pixel <= ovl;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_pixel();
    logic [7:0] alpha;
    case ($urandom_range(0, 5))
      0:       alpha = 8'h00;
      1:       alpha = 8'hFF;
      2:       alpha = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      default: alpha = 8'($urandom);
    endcase
    send_pixel($urandom, 16'($urandom), {alpha, 24'($urandom)});
  endtask

  // stop offering and wait until every predicted pixel has come out
  task automatic wait_for_results();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
  endtask

  task automatic load_config(logic [7:0] mask, logic [10:0] fmt_v, logic [10:0] swap_v,
                             logic [10:0] dw, logic [10:0] dh, logic [10:0] sw,
                             logic [10:0] sh, logic [10:0] ow, logic [10:0] oh);
    if (mask[REG_PIXEL_FORMAT])  set_reg(REG_PIXEL_FORMAT, fmt_v);
    if (mask[REG_SWAP_BYTES])    set_reg(REG_SWAP_BYTES, swap_v);
    if (mask[REG_DISP_WIDTH])    set_reg(REG_DISP_WIDTH, dw);
    if (mask[REG_DISP_HEIGHT])   set_reg(REG_DISP_HEIGHT, dh);
    if (mask[REG_SOURCE_WIDTH])  set_reg(REG_SOURCE_WIDTH, sw);
    if (mask[REG_SOURCE_HEIGHT]) set_reg(REG_SOURCE_HEIGHT, sh);
    if (mask[REG_OVL_WIDTH])     set_reg(REG_OVL_WIDTH, ow);
    if (mask[REG_OVL_HEIGHT])    set_reg(REG_OVL_HEIGHT, oh);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [10:0] pick_dim(int typ);
    case ($urandom_range(0, 19))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd1024;
      3:       return 11'd1025;
      4:       return 11'd2047;
      default: return 11'($urandom_range(1, typ));
    endcase
  endfunction

  // area size against an effective display size
  function automatic logic [10:0] pick_area(logic [10:0] disp);
    int lim;
    lim = (disp == 0) ? 1 : ((disp > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : int'(disp));
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'(lim);
      3:       return 11'(lim + $urandom_range(1, 3));
      default: return 11'($urandom_range(0, lim));
    endcase
  endfunction

  task automatic load_random_config();
    logic [10:0] dw;
    logic [10:0] dh;
    logic [7:0]  mask;
    dw   = pick_dim(24);
    dh   = pick_dim(6);
    mask = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF;
    load_config(mask, 11'($urandom), 11'($urandom), dw, dh, pick_area(dw), pick_area(dh),
                pick_area(dw), pick_area(dh));
  endtask

  initial begin
    int phase_no;
    int n;
    phase_no = 0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_PIXEL_FORMAT;
    cfg_data             <= '0;
    pix_in.valid         <= 1'b0;
    pix_in.source_pixel  <= '0;
    pix_in.old_pixel     <= '0;
    pix_in.overlay_pixel <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers at their reset values
    send_pixel(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 16'hFFFF, 32'h0000_0000);
    send_pixel(32'h1234_5678, 16'h5A5A, 32'h80FF_FFFF);
    wait_for_results();

    // display shrunk mid-line; source 3x2 and overlay 4x3 inside a 5x3 display
    load_config(8'hFF, 11'(FMT_RGB565), 11'd0, 11'd5, 11'd3, 11'd3, 11'd2, 11'd4, 11'd3);
    send_pixel(32'hFFFF_FFFF, 16'hFFFF, 32'h00FF_FFFF);
    send_pixel(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 16'h0000, 32'hFF00_0000);
    send_pixel(32'h0000_0000, 16'hFFFF, 32'h80FF_FFFF);
    send_pixel(32'h0000_F81F, 16'h0000, 32'h01FF_00FF);
    send_pixel(32'hFFFF_0000, 16'h1234, 32'hFE00_FF00);
    send_pixel(32'h0000_0000, 16'hABCD, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 16'h0000, 32'h7F12_3456);
    send_pixel(32'h0000_0000, 16'hFFFF, 32'h00FF_FFFF);
    send_random_pixel();
    send_pixel(32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    send_pixel(32'hA5A5_A5A5, 16'h7E0F, 32'h4000_0000);
    wait_for_results();

    // black format, byte swap, zero display size taken as one pixel
    load_config(8'hFF, 11'(FMT_BLACK), 11'd1, 11'd0, 11'd0, 11'd1, 11'd1, 11'd0, 11'd1);
    send_pixel(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 16'h1234, 32'h0000_0000);
    send_pixel(32'h1234_5678, 16'h0000, 32'h8012_3456);
    wait_for_results();

    // RGB888 with swap on an odd-sized line
    load_config(8'hFF, 11'(FMT_RGB888), 11'd1, 11'd3, 11'd1, 11'd2, 11'd1, 11'd1, 11'd1);
    send_pixel(32'h00FF_FFFF, 16'h0000, 32'h8000_0000);
    send_pixel(32'hFF12_3456, 16'hFFFF, 32'hFF00_0000);
    send_pixel(32'h0080_4020, 16'hC3C3, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 16'h0001, 32'h0100_0000);
    wait_for_results();

    while (items_sent < TOTAL_ITEMS) begin
      phase_no++;
      if (phase_no == 2) begin
        // a full clamped line so the column counter reaches its top value
        load_config(8'hFF, 11'($urandom), 11'($urandom), 11'd2047, 11'd2,
                    11'($urandom_range(0, 1024)), 11'($urandom_range(0, 3)),
                    11'($urandom_range(0, 1024)), 11'($urandom_range(0, 3)));
        n = LONG_LINE;
      end else begin
        load_random_config();
        n = $urandom_range(10, 60);
      end
      if (phase_no == 1) begin
        // long receiver hold-off while the sender keeps offering items
        hold_reqs++;
        burst_left = 200;
        n = 80;
      end
      repeat (n) send_random_pixel();
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
